>>> hw/rtl/qdr_pkg.sv
`default_nettype none

package qdr_pkg;

    localparam int CODE_W     = 9;
    localparam int PROD_W     = 18;
    localparam int TOTAL_W    = 32;
    localparam int COUNT_W    = 15;
    localparam int MAX_DEPTH  = 16384;
    localparam int MULT_W     = 32;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_ACT_ZP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ZP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LO  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HI  = 2'd3;

    typedef struct packed {
        logic [TOTAL_W-1:0] pair;
        logic [TOTAL_W-1:0] act;
        logic [TOTAL_W-1:0] wt;
        logic [COUNT_W-1:0] count;
    } totals_t;

endpackage

`default_nettype wire

>>> hw/rtl/qdr_lane.sv
`default_nettype none

module qdr_lane
    import qdr_pkg::*;
(
    input  wire logic                     en,
    input  wire logic signed [CODE_W-1:0] a,
    input  wire logic signed [CODE_W-1:0] b,
    output logic signed [PROD_W-1:0]      prod,
    output logic signed [CODE_W-1:0]      a_m,
    output logic signed [CODE_W-1:0]      b_m
);

    assign a_m  = en ? a : '0;
    assign b_m  = en ? b : '0;
    assign prod = a_m * b_m;

endmodule

`default_nettype wire

>>> hw/rtl/qdr_merge.sv
`default_nettype none

module qdr_merge
    import qdr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire logic                     last,
    input  wire logic                     second,
    input  wire logic signed [PROD_W-1:0] prod0,
    input  wire logic signed [PROD_W-1:0] prod1,
    input  wire logic signed [CODE_W-1:0] a0,
    input  wire logic signed [CODE_W-1:0] a1,
    input  wire logic signed [CODE_W-1:0] b0,
    input  wire logic signed [CODE_W-1:0] b1,
    output totals_t                       tot_next
);

    totals_t tot_reg;

    logic signed [PROD_W:0]   pair_sum;
    logic signed [15:0]       pair_sat;
    logic [TOTAL_W-1:0]       act_add;
    logic [TOTAL_W-1:0]       wt_add;
    logic [COUNT_W-1:0]       cnt_sum;

    always_comb
    begin
        pair_sum = PROD_W'(0) + {prod0[PROD_W-1], prod0} + {prod1[PROD_W-1], prod1};
        if (pair_sum > 19'sd32767)
        begin
            pair_sat = 16'sh7FFF;
        end
        else if (pair_sum < -19'sd32768)
        begin
            pair_sat = 16'sh8000;
        end
        else
        begin
            pair_sat = pair_sum[15:0];
        end
        act_add = {{(TOTAL_W-CODE_W){a0[CODE_W-1]}}, a0}
                + {{(TOTAL_W-CODE_W){a1[CODE_W-1]}}, a1};
        wt_add  = {{(TOTAL_W-CODE_W){b0[CODE_W-1]}}, b0}
                + {{(TOTAL_W-CODE_W){b1[CODE_W-1]}}, b1};
        cnt_sum = tot_reg.count + (second ? COUNT_W'(2) : COUNT_W'(1));

        tot_next.pair  = tot_reg.pair + {{(TOTAL_W-16){pair_sat[15]}}, pair_sat};
        tot_next.act   = tot_reg.act + act_add;
        tot_next.wt    = tot_reg.wt + wt_add;
        tot_next.count = (cnt_sum > COUNT_MAX) ? COUNT_MAX : cnt_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_reg <= '0;
        end
        else if (accept)
        begin
            tot_reg <= last ? '0 : tot_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/qdr_requant.sv
`default_nettype none

module qdr_requant
    import qdr_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire totals_t                  tot,
    input  wire logic signed [CODE_W-1:0] wzp,
    input  wire logic [MULT_W-1:0]        mult,
    input  wire logic signed [CODE_W-1:0] azp,
    input  wire logic signed [CODE_W-1:0] ozp,
    input  wire logic signed [CODE_W-1:0] clamp_lo,
    input  wire logic signed [CODE_W-1:0] clamp_hi,
    output logic                          idle,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [CODE_W-1:0]             y_code
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_ZC   = 4'd2;
    localparam logic [3:0] S_SUM  = 4'd3;
    localparam logic [3:0] S_ABS  = 4'd4;
    localparam logic [3:0] S_NORM = 4'd5;
    localparam logic [3:0] S_RND1 = 4'd6;
    localparam logic [3:0] S_MUL2 = 4'd7;
    localparam logic [3:0] S_RND2 = 4'd8;
    localparam logic [3:0] S_INT  = 4'd9;
    localparam logic [3:0] S_CLMP = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0]               state_reg;
    logic [3:0]               state_next;
    totals_t                  tot_reg;
    logic signed [CODE_W-1:0] wzp_reg;
    logic [MULT_W-1:0]        mult_reg;
    logic [TOTAL_W-1:0]       t1_reg;
    logic [TOTAL_W-1:0]       t2_reg;
    logic signed [PROD_W-1:0] zz_reg;
    logic [TOTAL_W-1:0]       zc_reg;
    logic [TOTAL_W-1:0]       acc_reg;
    logic                     sign_reg;
    logic                     zero_reg;
    logic                     sat_reg;
    logic [31:0]              n_reg;
    logic [4:0]               sh_reg;
    logic [23:0]              ma_reg;
    logic [5:0]               ea_reg;
    logic [47:0]              p_reg;
    logic [23:0]              m_reg;
    logic signed [9:0]        ef_reg;
    logic [10:0]              q_reg;
    logic [CODE_W-1:0]        y_reg;
    logic                     out_valid_reg;

    logic signed [40:0]       t1_full;
    logic signed [40:0]       t2_full;
    logic signed [PROD_W-1:0] zz_next;
    logic signed [33:0]       zc_full;
    logic [TOTAL_W-1:0]       acc_next;
    logic [31:0]              mag_next;
    logic [7:0]               expf;
    logic [22:0]              frac;
    logic                     zero_next;
    logic                     sat_next;
    logic [31:0]              n_next;
    logic [4:0]               sh_next;
    logic                     inc1;
    logic [24:0]              ma25;
    logic [23:0]              ma_next;
    logic [5:0]               ea_next;
    logic [47:0]              p_next;
    logic signed [9:0]        em;
    logic signed [9:0]        ef_base;
    logic [23:0]              t24;
    logic                     g2;
    logic                     st2;
    logic [24:0]              m25;
    logic [23:0]              m_next;
    logic signed [9:0]        ef_next;
    logic signed [9:0]        ef_neg;
    logic [47:0]              shifted;
    logic [11:0]              q_round;
    logic [10:0]              q_next;
    logic signed [12:0]       v0;
    logic signed [12:0]       v1;
    logic signed [12:0]       v2;
    logic signed [12:0]       lo_ext;
    logic signed [12:0]       hi_ext;
    logic [CODE_W-1:0]        y_next;

    always_comb
    begin
        t1_full  = wzp_reg * $signed(tot_reg.act);
        t2_full  = azp * $signed(tot_reg.wt);
        zz_next  = azp * wzp_reg;
        zc_full  = zz_reg * $signed({1'b0, tot_reg.count});
        acc_next = tot_reg.pair - t1_reg - t2_reg + zc_reg;
        mag_next = acc_reg[31] ? (~acc_reg + 32'd1) : acc_reg;

        expf      = mult_reg[30:23];
        frac      = mult_reg[22:0];
        zero_next = (expf == 8'hFF && frac != 23'd0) || acc_reg == '0 || expf == 8'd0;
        sat_next  = !zero_next && expf == 8'hFF;

        if (n_reg[31:24] == 8'd0)
        begin
            n_next  = {n_reg[23:0], 8'd0};
            sh_next = sh_reg + 5'd8;
        end
        else
        begin
            n_next  = {n_reg[30:0], 1'b0};
            sh_next = sh_reg + 5'd1;
        end

        inc1    = n_reg[7] & ((|n_reg[6:0]) | n_reg[8]);
        ma25    = {1'b0, n_reg[31:8]} + {24'd0, inc1};
        ma_next = ma25[24] ? 24'h800000 : ma25[23:0];
        ea_next = (ma25[24] ? 6'd32 : 6'd31) - {1'b0, sh_reg};

        p_next = ma_reg * {1'b1, frac};

        em      = $signed({2'b00, expf}) - 10'sd127;
        ef_base = $signed({4'b0000, ea_reg}) + em - (p_reg[47] ? 10'sd22 : 10'sd23);
        t24     = p_reg[47] ? p_reg[47:24] : p_reg[46:23];
        g2      = p_reg[47] ? p_reg[23] : p_reg[22];
        st2     = p_reg[47] ? (|p_reg[22:0]) : (|p_reg[21:0]);
        m25     = {1'b0, t24} + {24'd0, g2 & (st2 | t24[0])};
        m_next  = m25[24] ? 24'h800000 : m25[23:0];
        ef_next = ef_base + (m25[24] ? 10'sd1 : 10'sd0);

        ef_neg  = -ef_reg;
        shifted = {m_reg, 24'd0} >> ef_neg[4:0];
        q_round = shifted[35:24]
                + {11'd0, shifted[23] & ((|shifted[22:0]) | shifted[24])};
        if (zero_reg)
        begin
            q_next = '0;
        end
        else if (sat_reg || ef_reg >= -10'sd13)
        begin
            q_next = 11'd1024;
        end
        else if (ef_reg < -10'sd24)
        begin
            q_next = '0;
        end
        else
        begin
            q_next = q_round[10:0];
        end

        lo_ext = $signed({{4{clamp_lo[CODE_W-1]}}, clamp_lo});
        hi_ext = $signed({{4{clamp_hi[CODE_W-1]}}, clamp_hi});
        v0 = (sign_reg ? -$signed({2'b00, q_reg}) : $signed({2'b00, q_reg}))
           + $signed({{4{ozp[CODE_W-1]}}, ozp});
        v1 = (v0 < lo_ext) ? lo_ext : v0;
        v2 = (v1 > hi_ext) ? hi_ext : v1;
        y_next = v2[CODE_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: state_next = start ? S_MUL : S_IDLE;
            S_MUL:  state_next = S_ZC;
            S_ZC:   state_next = S_SUM;
            S_SUM:  state_next = S_ABS;
            S_ABS:  state_next = (zero_next || sat_next) ? S_INT : S_NORM;
            S_NORM: state_next = n_reg[31] ? S_RND1 : S_NORM;
            S_RND1: state_next = S_MUL2;
            S_MUL2: state_next = S_RND2;
            S_RND2: state_next = S_INT;
            S_INT:  state_next = S_CLMP;
            S_CLMP: state_next = S_OUT;
            S_OUT:  state_next = (!out_valid_reg || out_ready) ? S_IDLE : S_OUT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                tot_reg  <= tot;
                wzp_reg  <= wzp;
                mult_reg <= mult;
            end
            S_MUL:
            begin
                t1_reg <= t1_full[TOTAL_W-1:0];
                t2_reg <= t2_full[TOTAL_W-1:0];
                zz_reg <= zz_next;
            end
            S_ZC:   zc_reg <= zc_full[TOTAL_W-1:0];
            S_SUM:  acc_reg <= acc_next;
            S_ABS:
            begin
                n_reg    <= mag_next;
                sh_reg   <= '0;
                sign_reg <= acc_reg[31] ^ mult_reg[31];
                zero_reg <= zero_next;
                sat_reg  <= sat_next;
            end
            S_NORM:
            begin
                if (!n_reg[31])
                begin
                    n_reg  <= n_next;
                    sh_reg <= sh_next;
                end
            end
            S_RND1:
            begin
                ma_reg <= ma_next;
                ea_reg <= ea_next;
            end
            S_MUL2: p_reg <= p_next;
            S_RND2:
            begin
                m_reg  <= m_next;
                ef_reg <= ef_next;
            end
            S_INT:  q_reg <= q_next;
            S_CLMP: y_reg <= y_next;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            y_code <= y_reg;
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NORM |-> n_reg != 32'd0)
        else $error("normalizer entered with zero magnitude");

    a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INT |-> !(zero_reg && sat_reg))
        else $error("zero and saturate both flagged");

    a_clamp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && clamp_lo <= clamp_hi)
        |-> ($signed(y_reg) >= clamp_lo && $signed(y_reg) <= clamp_hi))
        else $error("result outside clamp window");

    a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside output state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> tot.count <= COUNT_MAX)
        else $error("element count above depth limit");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/quantized_dot_requantize_unit.sv
// Quantized dot product with fp32 requantization.
// Input stream: one beat carries two activation/weight code pairs, the column
// weight zero point and the fp32 multiplier; tuser flags the second pair as
// present, tlast closes the dot product. Non-last beats are taken one per
// cycle and folded into the running totals by two multiply lanes.
// On the last beat the input stalls while the correction, int-to-float
// conversion, fp32 multiply and half-even rounding run in a sequencer.
// A zero, NaN or infinite product skips the leading-one search on the
// corrected sum and the multiply; otherwise the search runs one byte or
// one bit per cycle.
// The running totals clear as the last beat is taken.
// Output stream: one 9-bit code per dot product, held in an output register;
// a stalled receiver holds that beat while new input beats keep arriving;
// the next result waits for it in the sequencer, and the input stalls then.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 activation
// zero point, 1 output zero point, 2 clamp low, 3 clamp high); the user must
// write only while idle, the block does not enforce it. Reset: totals clear,
// zero points and clamp low go to 0, clamp high to 255, no result pending.
`default_nettype none

module quantized_dot_requantize_unit
    import qdr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // act_first, wt_first, act_second, wt_second, weight_zero_point, multiplier
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // second_valid
    input  wire logic                   s_axis_tuser,
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // y_code
    output logic [OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CODE_W-1:0]      cfg_data
);

    logic signed [CODE_W-1:0] azp_reg;
    logic signed [CODE_W-1:0] ozp_reg;
    logic signed [CODE_W-1:0] lo_reg;
    logic signed [CODE_W-1:0] hi_reg;

    logic                     accept;
    logic                     idle;
    logic signed [PROD_W-1:0] prod0;
    logic signed [PROD_W-1:0] prod1;
    logic signed [CODE_W-1:0] a0;
    logic signed [CODE_W-1:0] a1;
    logic signed [CODE_W-1:0] b0;
    logic signed [CODE_W-1:0] b1;
    totals_t                  tot_next;
    logic [CODE_W-1:0]        y_code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            azp_reg <= '0;
            ozp_reg <= '0;
            lo_reg  <= '0;
            hi_reg  <= 9'sd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ACT_ZP:   azp_reg <= cfg_data;
                CFG_OUT_ZP:   ozp_reg <= cfg_data;
                CFG_CLAMP_LO: lo_reg  <= cfg_data;
                CFG_CLAMP_HI: hi_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = idle;
    assign accept        = s_axis_tvalid && idle;

    qdr_lane u_lane0 (
        .en   (1'b1),
        .a    (s_axis_tdata[8:0]),
        .b    (s_axis_tdata[17:9]),
        .prod (prod0),
        .a_m  (a0),
        .b_m  (b0)
    );

    qdr_lane u_lane1 (
        .en   (s_axis_tuser),
        .a    (s_axis_tdata[26:18]),
        .b    (s_axis_tdata[35:27]),
        .prod (prod1),
        .a_m  (a1),
        .b_m  (b1)
    );

    qdr_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .last     (s_axis_tlast),
        .second   (s_axis_tuser),
        .prod0    (prod0),
        .prod1    (prod1),
        .a0       (a0),
        .a1       (a1),
        .b0       (b0),
        .b1       (b1),
        .tot_next (tot_next)
    );

    qdr_requant u_requant (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept && s_axis_tlast),
        .tot       (tot_next),
        .wzp       (s_axis_tdata[44:36]),
        .mult      (s_axis_tdata[76:45]),
        .azp       (azp_reg),
        .ozp       (ozp_reg),
        .clamp_lo  (lo_reg),
        .clamp_hi  (hi_reg),
        .idle      (idle),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .y_code    (y_code)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-CODE_W){1'b0}}, y_code};

endmodule

`default_nettype wire
